// ===== hw/rtl/utf8_line_splitter_top_assert.svh =====
// ----------------------------------------------------------------------------
// utf8_line_splitter_top_assert.svh
// Assertion macros used by the line splitter queue (uls_fifo).
// ----------------------------------------------------------------------------
`ifndef UTF8_LINE_SPLITTER_TOP_ASSERT_SVH
`define UTF8_LINE_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ULS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ULS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/uls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uls_pkg
// Shared types and constants of the UTF-8 line splitter.
// ----------------------------------------------------------------------------
package uls_pkg;

  localparam int unsigned LENGTH_BITS_DEF     = 16;
  localparam int unsigned LINE_COUNT_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH         = 4;

  localparam logic [7:0] BYTE_NUL     = 8'h00;
  localparam logic [7:0] BYTE_LF      = 8'd10;
  localparam logic [7:0] BYTE_CR      = 8'd13;
  localparam logic [7:0] BYTE_ASCII   = 8'h80;
  localparam logic [7:0] BYTE_CONT_MK = 8'hC0;
  localparam logic [7:0] BYTE_LEAD2   = 8'hC0;
  localparam logic [7:0] BYTE_LEAD3   = 8'hE0;
  localparam logic [7:0] BYTE_LEAD4   = 8'hF0;
  localparam logic [7:0] BYTE_BAD     = 8'hF8;
  localparam logic [7:0] BYTE_CONT    = 8'h80;

  typedef enum logic [1:0] {
    CAUSE_END = 2'd0,
    CAUSE_NUL = 2'd1,
    CAUSE_BAD = 2'd2,
    CAUSE_RSV = 2'd3
  } uls_cause_t;

  typedef enum logic [1:0] {
    RT_CHARWISE  = 2'd0,
    RT_LINEWISE  = 2'd1,
    RT_BLOCKWISE = 2'd2,
    RT_AUTO      = 2'd3
  } uls_rtype_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } uls_q_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/uls_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uls_if
// Valid/ready channels of the UTF-8 line splitter.
// ----------------------------------------------------------------------------
interface uls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface uls_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface uls_out_if import uls_pkg::*; #(
  parameter int unsigned LENGTH_BITS     = LENGTH_BITS_DEF,
  parameter int unsigned LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [LENGTH_BITS-1:0]     line_length;
  logic [LINE_COUNT_BITS-1:0] line_number;
  logic                       is_final;
  logic [1:0]                 reg_type;
  logic [1:0]                 stop_cause;

  modport source (output valid, output line_length, output line_number, output is_final,
                  output reg_type, output stop_cause, input ready);
  modport sink   (input valid, input line_length, input line_number, input is_final,
                  input reg_type, input stop_cause, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/utf8_line_splitter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_line_splitter_top
// UTF-8 validating line splitter.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one byte of the text buffer per item, last_byte on its final byte.
//   cfg_ch : register type mode (0 charwise, 1 linewise, 2 blockwise, 3 auto);
//            always ready, write only while the block is idle.
//   out_ch : one item per line: length, number, and on the final line the
//            register type and stop cause.
// Throughput: one byte per cycle while the queue has room. A byte that ends a line
// and the buffer at once yields two items, sent one after the other.
// Path: the record of a line or buffer end is written into the queue at the
// accepting edge, then loaded into the output registers once the output stage
// takes it from the queue.
// Stall: a stalled receiver fills the four-record queue between classifier
// and output stage; in_ch.ready then drops until a record drains.
// Reset: mode returns to auto, line state clears, queue and output empty.
// No memory clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_line_splitter_top import uls_pkg::*; #(
  parameter int unsigned LENGTH_BITS     = LENGTH_BITS_DEF,
  parameter int unsigned LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  uls_in_if.sink     in_ch,
  uls_cfg_if.sink    cfg_ch,
  uls_out_if.source  out_ch
);

  localparam int unsigned ENTRY_W = 2 * (LENGTH_BITS + LINE_COUNT_BITS) + 6;

  uls_q_status_t      q_status;
  logic               push, pop;
  logic [ENTRY_W-1:0] wr_entry, rd_entry;

  uls_front #(
    .LENGTH_BITS     (LENGTH_BITS),
    .LINE_COUNT_BITS (LINE_COUNT_BITS),
    .ENTRY_W         (ENTRY_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_status (q_status),
    .push     (push),
    .entry    (wr_entry)
  );

  uls_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .status  (q_status)
  );

  uls_back #(
    .LENGTH_BITS     (LENGTH_BITS),
    .LINE_COUNT_BITS (LINE_COUNT_BITS),
    .ENTRY_W         (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .entry    (rd_entry),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/uls_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uls_fifo
// Short register queue between the classifier front and the output back.
// ----------------------------------------------------------------------------
`include "utf8_line_splitter_top_assert.svh"
module uls_fifo import uls_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output uls_q_status_t    status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == CNT_FULL);
  assign status.empty = (count_r == '0);
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `ULS_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !status.full, "queue push while full")
  `ULS_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, !status.empty, "queue pop while empty")
  `ULS_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1, "queue count did not advance on push")

endmodule
`default_nettype wire

// ===== hw/rtl/uls_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uls_front
// Byte classifier: UTF-8 checks, line and CR tracking, result records.
// ----------------------------------------------------------------------------
module uls_front import uls_pkg::*; #(
  parameter int unsigned LENGTH_BITS     = LENGTH_BITS_DEF,
  parameter int unsigned LINE_COUNT_BITS = LINE_COUNT_BITS_DEF,
  parameter int unsigned ENTRY_W         = 2 * (LENGTH_BITS + LINE_COUNT_BITS) + 6
) (
  input  logic               clk,
  input  logic               rst_n,
  uls_in_if.sink             in_ch,
  uls_cfg_if.sink            cfg_ch,
  input  uls_q_status_t      q_status,
  output logic               push,
  output logic [ENTRY_W-1:0] entry
);

  localparam int unsigned LB  = LENGTH_BITS;
  localparam int unsigned LCB = LINE_COUNT_BITS;

  uls_rtype_t         mode_r;
  logic               cr_r, cr_nxt, cr_upd;
  logic [1:0]         cont_r, cont_nxt, cont_upd;
  logic [LB-1:0]      len_r, len_nxt, len_upd;
  logic [LCB-1:0]     line_r, line_nxt, line_upd;
  logic               stop_r, stop_nxt;

  logic               accept;
  logic [7:0]         b;
  logic               stop_byte;
  logic               emit_line;
  uls_cause_t         cause;
  uls_rtype_t         rtype;
  logic [LB:0]        acc_sum, cr_sum, fin_sum;
  logic [LB-1:0]      acc_len, cr_len, fin_len;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_status.full;
  assign accept       = in_ch.valid && in_ch.ready;
  assign b            = in_ch.data_byte;

  // Saturating length updates: a pending CR counts once the next byte is not LF
  assign acc_sum = {1'b0, len_r} + (LB + 1)'(cr_r) + (LB + 1)'(1);
  assign acc_len = acc_sum[LB] ? '1 : acc_sum[LB-1:0];
  assign cr_sum  = {1'b0, len_r} + (LB + 1)'(cr_r);
  assign cr_len  = cr_sum[LB] ? '1 : cr_sum[LB-1:0];

  always_comb begin
    len_upd   = len_r;
    cr_upd    = cr_r;
    cont_upd  = cont_r;
    line_upd  = line_r;
    stop_byte = 1'b0;
    emit_line = 1'b0;
    cause     = CAUSE_END;
    if (cont_r != 2'd0) begin
      if ((b & BYTE_CONT_MK) != BYTE_CONT) begin
        stop_byte = 1'b1;
        cause     = CAUSE_BAD;
      end else begin
        cont_upd = cont_r - 2'd1;
        len_upd  = acc_len;
        cr_upd   = 1'b0;
      end
    end else if (b == BYTE_NUL) begin
      stop_byte = 1'b1;
      cause     = CAUSE_NUL;
    end else if (b == BYTE_LF) begin
      emit_line = 1'b1;
      if (line_r != '1) begin
        line_upd = line_r + LCB'(1);
      end
      len_upd = '0;
      cr_upd  = 1'b0;
    end else if (b == BYTE_CR) begin
      len_upd = cr_len;
      cr_upd  = 1'b1;
    end else if (b < BYTE_ASCII) begin
      len_upd = acc_len;
      cr_upd  = 1'b0;
    end else if (b < BYTE_LEAD2) begin
      stop_byte = 1'b1;
      cause     = CAUSE_BAD;
    end else if (b < BYTE_LEAD3) begin
      len_upd  = acc_len;
      cr_upd   = 1'b0;
      cont_upd = 2'd1;
    end else if (b < BYTE_LEAD4) begin
      len_upd  = acc_len;
      cr_upd   = 1'b0;
      cont_upd = 2'd2;
    end else if (b < BYTE_BAD) begin
      len_upd  = acc_len;
      cr_upd   = 1'b0;
      cont_upd = 2'd3;
    end else begin
      stop_byte = 1'b1;
      cause     = CAUSE_BAD;
    end
  end

  // Final line: pending CR counts, register type follows the mode (auto: charwise if length nonzero, else linewise)
  assign fin_sum = {1'b0, len_upd} + (LB + 1)'(cr_upd);
  assign fin_len = fin_sum[LB] ? '1 : fin_sum[LB-1:0];

  always_comb begin
    if (mode_r != RT_AUTO) begin
      rtype = mode_r;
    end else if (fin_len != '0) begin
      rtype = RT_CHARWISE;
    end else begin
      rtype = RT_LINEWISE;
    end
  end

  assign push  = accept && !stop_r && (emit_line || stop_byte || in_ch.last_byte);
  assign entry = {emit_line, (stop_byte || in_ch.last_byte), len_r, line_r,
                  fin_len, line_upd, rtype, cause};

  always_comb begin
    len_nxt  = len_r;
    cr_nxt   = cr_r;
    cont_nxt = cont_r;
    line_nxt = line_r;
    stop_nxt = stop_r;
    if (accept) begin
      if (in_ch.last_byte) begin
        len_nxt  = '0;
        cr_nxt   = 1'b0;
        cont_nxt = 2'd0;
        line_nxt = LCB'(1);
        stop_nxt = 1'b0;
      end else if (!stop_r) begin
        len_nxt  = len_upd;
        cr_nxt   = cr_upd;
        cont_nxt = cont_upd;
        line_nxt = line_upd;
        stop_nxt = stop_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RT_AUTO;
      len_r  <= '0;
      cr_r   <= 1'b0;
      cont_r <= 2'd0;
      line_r <= LCB'(1);
      stop_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mode_r <= uls_rtype_t'(cfg_ch.data);
      end
      len_r  <= len_nxt;
      cr_r   <= cr_nxt;
      cont_r <= cont_nxt;
      line_r <= line_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/uls_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uls_back
// Output stage: takes queue records and sends their one or two result items.
// ----------------------------------------------------------------------------
module uls_back import uls_pkg::*; #(
  parameter int unsigned LENGTH_BITS     = LENGTH_BITS_DEF,
  parameter int unsigned LINE_COUNT_BITS = LINE_COUNT_BITS_DEF,
  parameter int unsigned ENTRY_W         = 2 * (LENGTH_BITS + LINE_COUNT_BITS) + 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  uls_q_status_t      q_status,
  input  logic [ENTRY_W-1:0] entry,
  output logic               pop,
  uls_out_if.source          out_ch
);

  localparam int unsigned LB  = LENGTH_BITS;
  localparam int unsigned LCB = LINE_COUNT_BITS;

  logic           line_pend_r, line_pend_nxt;
  logic           fin_pend_r, fin_pend_nxt;
  logic [LB-1:0]  line_len_r, fin_len_r;
  logic [LCB-1:0] line_num_r, fin_num_r;
  logic [1:0]     rtype_r, cause_r;

  logic           e_line, e_fin;
  logic [LB-1:0]  e_line_len, e_fin_len;
  logic [LCB-1:0] e_line_num, e_fin_num;
  logic [1:0]     e_rtype, e_cause;
  logic           busy, take, sent;

  assign {e_line, e_fin, e_line_len, e_line_num, e_fin_len, e_fin_num,
          e_rtype, e_cause} = entry;

  assign busy = line_pend_r || fin_pend_r;
  assign sent = out_ch.valid && out_ch.ready;
  // Free once the last pending item of the record goes out
  assign take = !busy || (out_ch.ready && !(line_pend_r && fin_pend_r));
  assign pop  = take && !q_status.empty;

  assign out_ch.valid       = busy;
  assign out_ch.line_length = line_pend_r ? line_len_r : fin_len_r;
  assign out_ch.line_number = line_pend_r ? line_num_r : fin_num_r;
  assign out_ch.is_final    = !line_pend_r;
  assign out_ch.reg_type    = line_pend_r ? RT_CHARWISE : rtype_r;
  assign out_ch.stop_cause  = line_pend_r ? CAUSE_END : cause_r;

  always_comb begin
    line_pend_nxt = line_pend_r;
    fin_pend_nxt  = fin_pend_r;
    if (pop) begin
      line_pend_nxt = e_line;
      fin_pend_nxt  = e_fin;
    end else if (sent) begin
      if (line_pend_r) begin
        line_pend_nxt = 1'b0;
      end else begin
        fin_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pend_r <= 1'b0;
      fin_pend_r  <= 1'b0;
    end else begin
      line_pend_r <= line_pend_nxt;
      fin_pend_r  <= fin_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_len_r <= e_line_len;
      line_num_r <= e_line_num;
      fin_len_r  <= e_fin_len;
      fin_num_r  <= e_fin_num;
      rtype_r    <= e_rtype;
      cause_r    <= e_cause;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 line splitter. A clocked driver feeds
// buffer bytes from a pending queue, and a line predictor computes the lines
// each accepted byte must produce. A clocked monitor compares every output
// line against the oldest predicted one. Phases vary the register type mode
// and the idling of both sides, and include a long receiver hold-off and a
// sender pause.
// ----------------------------------------------------------------------------
module tb_top;
  import uls_pkg::*;

  localparam int LB             = LENGTH_BITS_DEF;
  localparam int LCB            = LINE_COUNT_BITS_DEF;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT    = 4000;
  localparam int PRINT_LIMIT    = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic [LB-1:0]  len;
    logic [LCB-1:0] num;
    logic           fin;
    uls_rtype_t     rt;
    uls_cause_t     cause;
  } line_rec_t;

  logic clk;
  logic rst_n;

  uls_in_if  in_ch ();
  uls_cfg_if cfg_ch ();
  uls_out_if out_ch ();

  utf8_line_splitter_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  text_byte_t  pending_bytes[$];
  line_rec_t   lines_due[$];
  int unsigned queued_bytes;
  int unsigned mismatches;
  int unsigned lines_seen;

  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        tx_pause;
  int unsigned hold_requests;
  int unsigned holds_done;
  int unsigned hold_left;

  // Splitter state as the predictor sees it
  logic           sp_after_cr;
  logic [1:0]     sp_cont;
  logic [LB-1:0]  sp_len;
  logic [LCB-1:0] sp_line;
  logic           sp_stopped;
  uls_rtype_t     sp_mode;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [LB-1:0] sat_len(input logic [LB-1:0] a, input logic [1:0] inc);
    logic [LB:0] s;
    s = {1'b0, a} + inc;
    return s[LB] ? {LB{1'b1}} : s[LB-1:0];
  endfunction

  function automatic void clear_stream();
    sp_after_cr = 1'b0;
    sp_cont     = 2'd0;
    sp_len      = '0;
    sp_line     = LCB'(1);
    sp_stopped  = 1'b0;
  endfunction

  // Count one octet, folding in a pending CR
  function automatic void take_octet();
    sp_len      = sat_len(sp_len, {1'b0, sp_after_cr} + 2'd1);
    sp_after_cr = 1'b0;
  endfunction

  task automatic split_octet(input logic [7:0] b, input logic last);
    line_rec_t     rec;
    logic          stop;
    uls_cause_t    cause;
    logic [LB-1:0] flen;
    stop  = 1'b0;
    cause = CAUSE_END;
    if (sp_stopped) begin
      if (last) clear_stream();
      return;
    end
    if (sp_cont != 2'd0) begin
      if ((b & BYTE_CONT_MK) != BYTE_CONT) begin
        stop  = 1'b1;
        cause = CAUSE_BAD;
      end else begin
        sp_cont = sp_cont - 2'd1;
        take_octet();
      end
    end else if (b == BYTE_NUL) begin
      stop  = 1'b1;
      cause = CAUSE_NUL;
    end else if (b == BYTE_LF) begin
      rec = '{len: sp_len, num: sp_line, fin: 1'b0, rt: RT_CHARWISE, cause: CAUSE_END};
      lines_due.push_back(rec);
      if (sp_line != {LCB{1'b1}}) sp_line = sp_line + 1'b1;
      sp_len      = '0;
      sp_after_cr = 1'b0;
    end else if (b == BYTE_CR) begin
      sp_len      = sat_len(sp_len, {1'b0, sp_after_cr});
      sp_after_cr = 1'b1;
    end else if (b < BYTE_ASCII) begin
      take_octet();
    end else if (b < BYTE_LEAD2) begin
      stop  = 1'b1;
      cause = CAUSE_BAD;
    end else if (b < BYTE_LEAD3) begin
      take_octet();
      sp_cont = 2'd1;
    end else if (b < BYTE_LEAD4) begin
      take_octet();
      sp_cont = 2'd2;
    end else if (b < BYTE_BAD) begin
      take_octet();
      sp_cont = 2'd3;
    end else begin
      stop  = 1'b1;
      cause = CAUSE_BAD;
    end
    if (stop || last) begin
      flen      = sat_len(sp_len, {1'b0, sp_after_cr});
      rec.len   = flen;
      rec.num   = sp_line;
      rec.fin   = 1'b1;
      rec.rt    = (sp_mode != RT_AUTO) ? sp_mode : ((flen != 0) ? RT_CHARWISE : RT_LINEWISE);
      rec.cause = cause;
      lines_due.push_back(rec);
      if (last) clear_stream();
      else sp_stopped = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] line item %0d: %s got 0x%0h want 0x%0h", $time, lines_seen, what, got,
               want);
    mismatches++;
  endtask

  // Input driver: advance to the next pending byte once the current one is taken
  always @(posedge clk) begin : byte_driver
    text_byte_t nxt;
    logic       give;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= 8'h00;
      in_ch.last_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) split_octet(in_ch.data_byte, in_ch.last_byte);
      if (!in_ch.valid || in_ch.ready) begin
        give = (pending_bytes.size() != 0) && !tx_pause &&
               ($urandom_range(0, 99) >= tx_idle_pct);
        if (give) begin
          nxt = pending_bytes.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= nxt.data;
          in_ch.last_byte <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off, counted here so the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left  <= RX_HOLD_CYCLES;
    end
  end

  always @(posedge clk) begin : line_monitor
    line_rec_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (lines_due.size() == 0) begin
          report_mismatch("unexpected line, length", out_ch.line_length, 0);
        end else begin
          want = lines_due.pop_front();
          if (out_ch.line_length !== want.len)
            report_mismatch("line_length", out_ch.line_length, want.len);
          if (out_ch.line_number !== want.num)
            report_mismatch("line_number", out_ch.line_number, want.num);
          if (out_ch.is_final !== want.fin)
            report_mismatch("is_final", out_ch.is_final, want.fin);
          if (out_ch.reg_type !== want.rt)
            report_mismatch("reg_type", out_ch.reg_type, want.rt);
          if (out_ch.stop_cause !== want.cause)
            report_mismatch("stop_cause", out_ch.stop_cause, want.cause);
        end
        lines_seen++;
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** utf8_line_splitter_top: FAILED **");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    pending_bytes.push_back('{data: b, last: last});
    queued_bytes++;
  endtask

  task automatic write_mode(input uls_rtype_t m);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= m;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    sp_mode = m;
  endtask

  // Hold until all bytes are taken and all lines are out, then let the block settle
  task automatic wait_quiet(input int settle);
    while (pending_bytes.size() != 0 || in_ch.valid || lines_due.size() != 0)
      @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  function automatic logic [7:0] cont_octet();
    return BYTE_CONT | 8'($urandom_range(0, 63));
  endfunction

  // One buffer: mostly well-formed text, sometimes broken, sometimes raw noise
  task automatic queue_random_buffer();
    logic [7:0] text_q[$];
    int         pick;
    int         k;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 10)) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          text_q.push_back(8'($urandom_range(1, 127)));
        end else if (pick < 50) begin
          text_q.push_back(BYTE_LF);
        end else if (pick < 58) begin
          text_q.push_back(BYTE_CR);
          text_q.push_back(BYTE_LF);
        end else if (pick < 63) begin
          text_q.push_back(BYTE_CR);
        end else if (pick < 71) begin
          text_q.push_back(BYTE_LEAD2 | 8'($urandom_range(0, 31)));
          text_q.push_back(cont_octet());
        end else if (pick < 79) begin
          text_q.push_back(BYTE_LEAD3 | 8'($urandom_range(0, 15)));
          repeat (2) text_q.push_back(cont_octet());
        end else if (pick < 86) begin
          text_q.push_back(BYTE_LEAD4 | 8'($urandom_range(0, 7)));
          repeat (3) text_q.push_back(cont_octet());
        end else if (pick < 92) begin
          // character cut short; a following byte that is no continuation breaks it
          text_q.push_back(BYTE_LEAD4 | 8'($urandom_range(0, 7)));
          repeat ($urandom_range(0, 2)) text_q.push_back(cont_octet());
        end else begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0: text_q.push_back(BYTE_NUL);
          1: text_q.push_back(cont_octet());
          2: text_q.push_back(BYTE_BAD | 8'($urandom_range(0, 7)));
          default: begin
            text_q.push_back(BYTE_LEAD3 | 8'($urandom_range(0, 15)));
            text_q.push_back(($urandom_range(0, 1) == 0) ? BYTE_LF : BYTE_NUL);
          end
        endcase
        repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (k = 0; k < text_q.size(); k++) push_byte(text_q[k], k == text_q.size() - 1);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned start;
    start = queued_bytes;
    while (queued_bytes - start < count) queue_random_buffer();
  endtask

  task automatic queue_directed();
    // multi-line buffer with CR LF and characters of every length; LF last
    push_byte(8'h7F, 1'b0);
    push_byte(BYTE_CR, 1'b0);
    push_byte(BYTE_LF, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(BYTE_LF, 1'b1);
    // stray continuation, then bytes ignored until last
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(BYTE_NUL, 1'b1);
    // NUL that is also the last byte
    push_byte(BYTE_NUL, 1'b1);
    // octet of F8 or above on an empty line
    push_byte(8'hF8, 1'b0);
    push_byte(8'h41, 1'b1);
    // buffer ends inside a character
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b1);
    // LF while a continuation is expected
    push_byte(8'hC3, 1'b0);
    push_byte(BYTE_LF, 1'b0);
    push_byte(8'h71, 1'b1);
    // lone CR at the end counts
    push_byte(BYTE_CR, 1'b1);
    push_byte(8'hFF, 1'b1);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = RT_AUTO;
    out_ch.ready    = 1'b0;
    tx_pause        = 1'b0;
    hold_requests   = 0;
    queued_bytes    = 0;
    mismatches      = 0;
    lines_seen      = 0;
    tx_idle_pct     = 7;
    rx_idle_pct     = 53;
    sp_mode         = RT_AUTO;
    clear_stream();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_mode(RT_AUTO);
    queue_directed();
    wait_quiet(8);

    write_mode(RT_CHARWISE);
    queue_random(150);
    hold_requests++;
    queue_random(40);
    while (hold_left != 0 || holds_done != hold_requests) @(negedge clk);
    // sender holds off until every line is out
    tx_pause = 1'b1;
    while (in_ch.valid || lines_due.size() != 0) @(negedge clk);
    tx_pause = 1'b0;
    queue_random(80);
    wait_quiet(8);

    tx_idle_pct = 53;
    rx_idle_pct = 7;
    write_mode(RT_LINEWISE);
    queue_random(270);
    wait_quiet(8);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_mode(RT_BLOCKWISE);
    queue_random(135);
    wait_quiet(8);
    write_mode(RT_AUTO);
    queue_random(135);
    wait_quiet(20);

    if (mismatches == 0) begin
      $display("** utf8_line_splitter_top: PASSED **");
    end else begin
      $display("** utf8_line_splitter_top: FAILED **");
    end
    $finish;
  end

endmodule
